@@ rtl/twodom_pkg.sv @@
// Shared types, constants and helper functions for the three-wheel odometry block.
// No dependencies; every other file in rtl imports this package.
package twodom_pkg;

    localparam int TRIG_ITERATIONS_DEF = 24;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // divider widths
    localparam int NUM_W = 64;
    localparam int DEN_W = 34;

    // angle work width (Q4.28 with headroom)
    localparam int ANG_W = 34;

    localparam logic signed [ANG_W-1:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] CORDIC_K    = 34'sd652032874;
    localparam logic signed [MUL_W-1:0] ONE_Q30     = 33'sd1073741824;
    localparam logic signed [31:0]      SMALL_THETA = 32'sd4194304;

    // register reset values
    localparam logic [31:0] INCH_PER_TICK_RST = 32'd10294732;
    localparam logic [30:0] LEFT_OFFSET_RST   = 31'd458752;
    localparam logic [30:0] RIGHT_OFFSET_RST  = 31'd458752;
    localparam logic [31:0] SIDE_OFFSET_RST   = 32'd327680;

    typedef logic [1:0] req_t;
    localparam req_t REQ_UPDATE     = 2'd0;
    localparam req_t REQ_FULL_RESET = 2'd1;
    localparam req_t REQ_CLEAR_POSE = 2'd2;
    localparam req_t REQ_CLEAR_BASE = 2'd3;

    // arctangent table, truncated Q2.30
    function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:  v = 32'sh3243F6A8;
            5'd1:  v = 32'sh1DAC6705;
            5'd2:  v = 32'sh0FADBAFC;
            5'd3:  v = 32'sh07F56EA6;
            5'd4:  v = 32'sh03FEAB76;
            5'd5:  v = 32'sh01FFD55B;
            5'd6:  v = 32'sh00FFFAAA;
            5'd7:  v = 32'sh007FFF55;
            5'd8:  v = 32'sh003FFFEA;
            5'd9:  v = 32'sh001FFFFD;
            5'd10: v = 32'sh000FFFFF;
            5'd11: v = 32'sh0007FFFF;
            5'd12: v = 32'sh0003FFFF;
            5'd13: v = 32'sh0001FFFF;
            5'd14: v = 32'sh0000FFFF;
            5'd15: v = 32'sh00007FFF;
            5'd16: v = 32'sh00003FFF;
            5'd17: v = 32'sh00001FFF;
            5'd18: v = 32'sh00000FFF;
            5'd19: v = 32'sh000007FF;
            5'd20: v = 32'sh000003FF;
            5'd21: v = 32'sh000001FF;
            5'd22: v = 32'sh000000FF;
            5'd23: v = 32'sh0000007F;
            5'd24: v = 32'sh0000003F;
            5'd25: v = 32'sh0000001F;
            5'd26: v = 32'sh0000000F;
            5'd27: v = 32'sh00000008;
            5'd28: v = 32'sh00000004;
            5'd29: v = 32'sh00000002;
            5'd30: v = 32'sh00000001;
            default: v = 32'sh00000000;
        endcase
        return v;
    endfunction

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if ((&v[PROD_W-1:31]) || (~|v[PROD_W-1:31])) begin
            r = v[31:0];
        end else if (v[PROD_W-1]) begin
            r = 32'sh80000000;
        end else begin
            r = 32'sh7FFFFFFF;
        end
        return r;
    endfunction

    // one step of reduction toward (-pi, pi]
    function automatic logic signed [ANG_W-1:0] wrap_step(input logic signed [ANG_W-1:0] z);
        logic signed [ANG_W-1:0] r;
        if (z > PI_Q28) begin
            r = z - TWO_PI_Q28;
        end else if (z <= -PI_Q28) begin
            r = z + TWO_PI_Q28;
        end else begin
            r = z;
        end
        return r;
    endfunction

endpackage

@@ rtl/twodom_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on twodom_pkg for operand widths.
module twodom_mul (
    input  logic                                 clk,
    input  logic signed [twodom_pkg::MUL_W-1:0]  a,
    input  logic signed [twodom_pkg::MUL_W-1:0]  b,
    output logic signed [twodom_pkg::PROD_W-1:0] p
);
    import twodom_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

@@ rtl/twodom_div.sv @@
// Radix-2 restoring divider, signed, quotient truncated toward zero.
// Depends on twodom_pkg for widths. One quotient bit per cycle.
module twodom_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [twodom_pkg::NUM_W-1:0] num,
    input  logic signed [twodom_pkg::DEN_W-1:0] den,
    output logic                                busy,
    output logic                                done,
    output logic signed [twodom_pkg::NUM_W-1:0] quot
);
    import twodom_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic               busy_reg;
    logic               done_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   quo_reg;

    logic [DEN_W:0]     trial;
    logic               fits;
    logic [DEN_W:0]     trial_sub;

    assign trial     = {rem_reg, quo_reg[NUM_W-1]};
    assign fits      = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            neg_reg <= num[NUM_W-1] ^ den[DEN_W-1];
            quo_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            den_reg <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

@@ rtl/twodom_cordic.sv @@
// Iterative rotation-mode CORDIC: angle reduction, quadrant fold, ITER rotations.
// Depends on twodom_pkg for the arctangent table and angle constants.
module twodom_cordic #(
    parameter int ITER = twodom_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [twodom_pkg::ANG_W-1:0] angle,
    output logic                                done,
    output logic signed [twodom_pkg::MUL_W-1:0] sin_out,
    output logic signed [twodom_pkg::MUL_W-1:0] cos_out
);
    import twodom_pkg::*;

    localparam int IDX_W = $clog2(ITER);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_WRAP = 2'd1;
    localparam logic [1:0] C_ROT  = 2'd2;

    logic [1:0]              st_reg;
    logic                    done_reg;
    logic                    neg_reg;
    logic [IDX_W-1:0]        i_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic signed [ANG_W-1:0] x_reg;
    logic signed [ANG_W-1:0] y_reg;

    logic signed [ANG_W-1:0] z_wr;
    logic signed [ANG_W-1:0] z_fold;
    logic                    fold;
    logic signed [ANG_W-1:0] dx;
    logic signed [ANG_W-1:0] dy;
    logic signed [ANG_W-1:0] at;
    logic signed [ANG_W-1:0] s_full;
    logic signed [ANG_W-1:0] c_full;

    always_comb
    begin
        z_wr = wrap_step(z_reg);
        if (z_reg > HALF_PI_Q28) begin
            z_fold = z_reg - PI_Q28;
            fold   = 1'b1;
        end else if (z_reg < -HALF_PI_Q28) begin
            z_fold = z_reg + PI_Q28;
            fold   = 1'b1;
        end else begin
            z_fold = z_reg;
            fold   = 1'b0;
        end
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        at = ANG_W'(atan_q30(5'(i_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg   <= C_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (st_reg)
                C_IDLE:
                begin
                    if (start) begin
                        st_reg <= C_WRAP;
                    end
                end
                C_WRAP:
                begin
                    if (z_wr == z_reg) begin
                        st_reg <= C_ROT;
                    end
                end
                C_ROT:
                begin
                    if (i_reg == IDX_W'(ITER - 1)) begin
                        st_reg   <= C_IDLE;
                        done_reg <= 1'b1;
                    end
                end
                default:
                begin
                    st_reg <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            C_IDLE:
            begin
                if (start) begin
                    z_reg <= angle;
                end
            end
            C_WRAP:
            begin
                if (z_wr != z_reg) begin
                    z_reg <= z_wr;
                end else begin
                    z_reg   <= {z_fold[ANG_W-3:0], 2'b00};
                    neg_reg <= fold;
                    x_reg   <= CORDIC_K;
                    y_reg   <= '0;
                    i_reg   <= '0;
                end
            end
            C_ROT:
            begin
                if (z_reg >= 0) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                i_reg <= i_reg + 1'b1;
            end
            default:
            begin
                z_reg <= z_reg;
            end
        endcase
    end

    assign s_full  = neg_reg ? -y_reg : y_reg;
    assign c_full  = neg_reg ? -x_reg : x_reg;
    assign sin_out = s_full[MUL_W-1:0];
    assign cos_out = c_full[MUL_W-1:0];
    assign done    = done_reg;

endmodule

@@ rtl/three_wheel_odometry_update.sv @@
// Top level of the three-tracking-wheel odometry block: sequencer, pose state, APB registers.
// Depends on twodom_pkg, twodom_mul, twodom_div and twodom_cordic.
//
// Each request carries absolute left, right and side encoder counts and a kind.
// An update turns the count changes into inches (Q16.16), divides the left-right
// difference by the track width to get the heading change (Q4.28), forms the arc
// chords, rotates them by the mid-arc heading and adds them to x and y; the heading
// is wrapped into (-pi, pi]. The other kinds clear the pose, the baselines, or both.
// Exactly one result, the pose after the request, comes out for every request.
// A request is taken only while the sequencer is idle; item_stall is high otherwise.
// After an update is taken item_stall stays high until the result is valid, through
// four travel steps, two passes through the 64-step bit-serial divider (heading
// change and chord factor), two CORDIC runs, ten chord and rotation steps on the
// shared multiplier and the heading wrap. Every 2*pi taken off a CORDIC angle or
// the new heading adds a further wrap step. A small heading change swaps the
// chord-factor division for a two-step reciprocal multiply, no heading change skips
// the first CORDIC and the second division, and a zero track width skips the first
// division as well. A clear request skips the datapath and goes straight to the
// result. A finished result waits in the output register, and the next request is
// accepted while it waits; a second result then holds the sequencer until the
// output register frees up. Registers sit at 0x0, 0x4, 0x8, 0xC.
module three_wheel_odometry_update #(
    parameter int TRIG_ITERATIONS = twodom_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // APB register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // request channel
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] left_ticks,
    input  logic signed [31:0] right_ticks,
    input  logic signed [31:0] side_ticks,
    // result channel
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [30:0] heading
);
    import twodom_pkg::*;

    localparam logic [1:0] REG_INCH_PER_TICK = 2'd0;
    localparam logic [1:0] REG_LEFT_OFFSET   = 2'd1;
    localparam logic [1:0] REG_RIGHT_OFFSET  = 2'd2;
    localparam logic [1:0] REG_SIDE_OFFSET   = 2'd3;

    // ceil(2^18 / 6): exact division by 6 for values below 2^17
    localparam logic signed [MUL_W-1:0] RECIP_SIX_Q18 = 33'sd43691;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_TL    = 5'd1;   // travel multiplies
    localparam logic [4:0] ST_TR    = 5'd2;
    localparam logic [4:0] ST_TS    = 5'd3;
    localparam logic [4:0] ST_TW    = 5'd4;
    localparam logic [4:0] ST_DIV1  = 5'd5;   // heading change division
    localparam logic [4:0] ST_THETA = 5'd6;
    localparam logic [4:0] ST_COR1  = 5'd7;   // sine of half angle
    localparam logic [4:0] ST_SQ    = 5'd8;   // small angle: square / 6
    localparam logic [4:0] ST_DIV2  = 5'd9;   // chord factor
    localparam logic [4:0] ST_CH1   = 5'd10;
    localparam logic [4:0] ST_CH2   = 5'd11;
    localparam logic [4:0] ST_CH3   = 5'd12;
    localparam logic [4:0] ST_CH4   = 5'd13;
    localparam logic [4:0] ST_CH5   = 5'd14;
    localparam logic [4:0] ST_COR2  = 5'd15;  // mid-arc sine and cosine
    localparam logic [4:0] ST_R1    = 5'd16;
    localparam logic [4:0] ST_R2    = 5'd17;
    localparam logic [4:0] ST_R3    = 5'd18;
    localparam logic [4:0] ST_R4    = 5'd19;
    localparam logic [4:0] ST_R5    = 5'd20;
    localparam logic [4:0] ST_WRAP  = 5'd21;
    localparam logic [4:0] ST_DONE  = 5'd22;
    localparam logic [4:0] ST_SQ2   = 5'd23;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    // configuration
    logic [31:0] ipt_reg;
    logic [30:0] lo_reg;
    logic [30:0] ro_reg;
    logic signed [31:0] so_reg;

    // baselines and pose
    logic [31:0] last_l_reg;
    logic [31:0] last_r_reg;
    logic [31:0] last_s_reg;
    logic signed [31:0] pose_x_reg;
    logic signed [31:0] pose_y_reg;
    logic signed [31:0] pose_hd_reg;

    // per-update working values
    logic signed [31:0] dl_reg;
    logic signed [31:0] dr_reg;
    logic signed [31:0] dm_reg;
    logic signed [31:0] tl_reg;
    logic signed [31:0] tr_reg;
    logic signed [31:0] tm_reg;
    logic signed [31:0] theta_reg;
    logic signed [MUL_W-1:0] g_reg;
    logic signed [MUL_W-1:0] f_reg;
    logic               small_reg;
    logic signed [31:0] h_reg;
    logic signed [31:0] h2_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [ANG_W-1:0]  hdw_reg;

    // result register
    logic               rvalid_reg;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic signed [30:0] out_hd_reg;

    // shared units
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start;
    logic signed [NUM_W-1:0]  div_num;
    logic signed [DEN_W-1:0]  div_den;
    logic                     div_busy;
    logic                     div_done;
    logic signed [NUM_W-1:0]  div_quot;
    logic                     cor_start;
    logic signed [ANG_W-1:0]  cor_angle;
    logic                     cor_done;
    logic signed [MUL_W-1:0]  cor_sin;
    logic signed [MUL_W-1:0]  cor_cos;

    logic               cfg_wr;
    logic               accept;
    logic               out_load;
    logic [31:0]        width;
    logic signed [30:0] x_half;
    logic signed [32:0] tdiff;
    logic signed [MUL_W-1:0]  g_val;
    logic signed [PROD_W-1:0] prod_sh30;
    logic signed [PROD_W-1:0] chord_sum;
    logic signed [PROD_W-1:0] rot_sum;
    logic signed [PROD_W-1:0] rot_dif;
    logic signed [ANG_W-1:0]  hd_wr;

    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_load   = (state_reg == ST_DONE) && (!rvalid_reg || !result_stall);

    assign width     = {1'b0, lo_reg} + {1'b0, ro_reg};
    assign x_half    = theta_reg[31:1];
    assign tdiff     = $signed({tl_reg[31], tl_reg}) - $signed({tr_reg[31], tr_reg});
    assign g_val     = $signed({cor_sin[31:0], 1'b0});
    assign prod_sh30 = prod >>> 30;
    assign chord_sum = acc_reg + prod_sh30;
    assign rot_sum   = acc_reg + prod;
    assign rot_dif   = acc_reg - prod;
    assign hd_wr     = wrap_step(hdw_reg);

    always_comb
    begin
        case (paddr[3:2])
            REG_INCH_PER_TICK: prdata = ipt_reg;
            REG_LEFT_OFFSET:   prdata = {1'b0, lo_reg};
            REG_RIGHT_OFFSET:  prdata = {1'b0, ro_reg};
            REG_SIDE_OFFSET:   prdata = so_reg;
            default:           prdata = '0;
        endcase
    end

    // multiplier operand select, product used in the following state
    always_comb
    begin
        case (state_reg)
            ST_TL:
            begin
                mul_a = MUL_W'(dl_reg);
                mul_b = $signed({1'b0, ipt_reg});
            end
            ST_TR:
            begin
                mul_a = MUL_W'(dr_reg);
                mul_b = $signed({1'b0, ipt_reg});
            end
            ST_TS:
            begin
                mul_a = MUL_W'(dm_reg);
                mul_b = $signed({1'b0, ipt_reg});
            end
            ST_COR1:
            begin
                mul_a = $signed({{2{x_half[30]}}, x_half});
                mul_b = $signed({{2{x_half[30]}}, x_half});
            end
            ST_SQ:
            begin
                // square >> 26 is at most 2^16
                mul_a = $signed({16'b0, prod[42:26]});
                mul_b = RECIP_SIX_Q18;
            end
            ST_CH1:
            begin
                mul_a = MUL_W'(tr_reg);
                mul_b = f_reg;
            end
            ST_CH2:
            begin
                mul_a = $signed({2'b00, ro_reg});
                mul_b = g_reg;
            end
            ST_CH3:
            begin
                mul_a = MUL_W'(tm_reg);
                mul_b = f_reg;
            end
            ST_CH4:
            begin
                mul_a = MUL_W'(so_reg);
                mul_b = g_reg;
            end
            ST_R1:
            begin
                mul_a = MUL_W'(h_reg);
                mul_b = cor_sin;
            end
            ST_R2:
            begin
                mul_a = MUL_W'(h2_reg);
                mul_b = cor_cos;
            end
            ST_R3:
            begin
                mul_a = MUL_W'(h_reg);
                mul_b = cor_cos;
            end
            ST_R4:
            begin
                mul_a = MUL_W'(h2_reg);
                mul_b = cor_sin;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider launch: heading change or chord factor
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            ST_TW:
            begin
                div_start = (width != '0);
                div_num   = $signed({{(NUM_W-61){tdiff[32]}}, tdiff, 28'b0});
                div_den   = $signed({2'b00, width});
            end
            ST_COR1:
            begin
                div_start = cor_done && !small_reg;
                div_num   = $signed({{(NUM_W-61){g_val[MUL_W-1]}}, g_val, 28'b0});
                div_den   = DEN_W'(theta_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cor_start = 1'b0;
        cor_angle = ANG_W'(x_half);
        if (state_reg == ST_THETA) begin
            cor_start = (theta_reg != '0);
        end else if (state_reg == ST_CH5) begin
            cor_start = 1'b1;
            cor_angle = ANG_W'(pose_hd_reg) + ANG_W'(x_half);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    state_next = (req_type == REQ_UPDATE) ? ST_TL : ST_DONE;
                end
            end
            ST_TL:    state_next = ST_TR;
            ST_TR:    state_next = ST_TS;
            ST_TS:    state_next = ST_TW;
            ST_TW:    state_next = (width != '0) ? ST_DIV1 : ST_THETA;
            ST_DIV1:
            begin
                if (div_done) begin
                    state_next = ST_THETA;
                end
            end
            ST_THETA: state_next = (theta_reg != '0) ? ST_COR1 : ST_CH1;
            ST_COR1:
            begin
                if (cor_done) begin
                    state_next = small_reg ? ST_SQ : ST_DIV2;
                end
            end
            ST_SQ:    state_next = ST_SQ2;
            ST_SQ2:   state_next = ST_CH1;
            ST_DIV2:
            begin
                if (div_done) begin
                    state_next = ST_CH1;
                end
            end
            ST_CH1:   state_next = ST_CH2;
            ST_CH2:   state_next = ST_CH3;
            ST_CH3:   state_next = ST_CH4;
            ST_CH4:   state_next = ST_CH5;
            ST_CH5:   state_next = ST_COR2;
            ST_COR2:
            begin
                if (cor_done) begin
                    state_next = ST_R1;
                end
            end
            ST_R1:    state_next = ST_R2;
            ST_R2:    state_next = ST_R3;
            ST_R3:    state_next = ST_R4;
            ST_R4:    state_next = ST_R5;
            ST_R5:    state_next = ST_WRAP;
            ST_WRAP:
            begin
                if (hd_wr == hdw_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state, configuration, baselines and pose
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            rvalid_reg  <= 1'b0;
            ipt_reg     <= INCH_PER_TICK_RST;
            lo_reg      <= LEFT_OFFSET_RST;
            ro_reg      <= RIGHT_OFFSET_RST;
            so_reg      <= SIDE_OFFSET_RST;
            last_l_reg  <= '0;
            last_r_reg  <= '0;
            last_s_reg  <= '0;
            pose_x_reg  <= '0;
            pose_y_reg  <= '0;
            pose_hd_reg <= '0;
        end else begin
            state_reg <= state_next;

            if (out_load) begin
                rvalid_reg <= 1'b1;
            end else if (!result_stall) begin
                rvalid_reg <= 1'b0;
            end

            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_INCH_PER_TICK: ipt_reg <= pwdata;
                    REG_LEFT_OFFSET:   lo_reg  <= pwdata[30:0];
                    REG_RIGHT_OFFSET:  ro_reg  <= pwdata[30:0];
                    REG_SIDE_OFFSET:   so_reg  <= pwdata;
                    default:           ipt_reg <= ipt_reg;
                endcase
            end

            if (accept) begin
                if (req_type == REQ_UPDATE) begin
                    last_l_reg <= left_ticks;
                    last_r_reg <= right_ticks;
                    last_s_reg <= side_ticks;
                end
                if (req_type == REQ_FULL_RESET || req_type == REQ_CLEAR_POSE) begin
                    pose_x_reg  <= '0;
                    pose_y_reg  <= '0;
                    pose_hd_reg <= '0;
                end
                if (req_type == REQ_FULL_RESET || req_type == REQ_CLEAR_BASE) begin
                    last_l_reg <= '0;
                    last_r_reg <= '0;
                    last_s_reg <= '0;
                end
            end

            if (state_reg == ST_R3) begin
                pose_x_reg <= pose_x_reg + rot_sum[61:30];
            end
            if (state_reg == ST_R5) begin
                pose_y_reg <= pose_y_reg + rot_dif[61:30];
            end
            if (state_reg == ST_WRAP && hd_wr == hdw_reg) begin
                pose_hd_reg <= hdw_reg[31:0];
            end
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                dl_reg <= left_ticks - last_l_reg;
                dr_reg <= right_ticks - last_r_reg;
                dm_reg <= side_ticks - last_s_reg;
            end
            ST_TR:   tl_reg <= sat32(prod >>> 16);
            ST_TS:   tr_reg <= sat32(prod >>> 16);
            ST_TW:
            begin
                tm_reg <= sat32(prod >>> 16);
                if (width == '0) begin
                    theta_reg <= '0;
                end
            end
            ST_DIV1:
            begin
                if (div_done) begin
                    theta_reg <= sat32(PROD_W'(div_quot));
                end
            end
            ST_THETA:
            begin
                small_reg <= (theta_reg < SMALL_THETA) && (theta_reg > -SMALL_THETA);
                f_reg     <= ONE_Q30;
                g_reg     <= '0;
            end
            ST_COR1:
            begin
                if (cor_done) begin
                    g_reg <= g_val;
                end
            end
            // series form: 1 - x^2/6, product holds (square >> 26) * 2^18/6
            ST_SQ2:  f_reg <= ONE_Q30 - $signed(prod[50:18]);
            ST_DIV2:
            begin
                if (div_done) begin
                    f_reg <= div_quot[MUL_W-1:0];
                end
            end
            ST_CH2:  acc_reg <= prod_sh30;
            ST_CH3:  h_reg   <= sat32(chord_sum);
            ST_CH4:  acc_reg <= prod_sh30;
            ST_CH5:  h2_reg  <= sat32(chord_sum);
            ST_R2:   acc_reg <= prod;
            ST_R4:   acc_reg <= prod;
            ST_R5:   hdw_reg <= ANG_W'(pose_hd_reg) + ANG_W'(theta_reg);
            ST_WRAP: hdw_reg <= hd_wr;
            default: acc_reg <= acc_reg;
        endcase

        if (out_load) begin
            out_x_reg  <= pose_x_reg;
            out_y_reg  <= pose_y_reg;
            out_hd_reg <= pose_hd_reg[30:0];
        end
    end

    twodom_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    twodom_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    twodom_cordic #(
        .ITER (TRIG_ITERATIONS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .sin_out (cor_sin),
        .cos_out (cor_cos)
    );

    assign result_valid = rvalid_reg;
    assign pos_x        = out_x_reg;
    assign pos_y        = out_y_reg;
    assign heading      = out_hd_reg;

    // a delivered heading is always wrapped
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (($signed(heading) <= PI_Q28) && ($signed(heading) >= -PI_Q28)))
        else $error("heading out of range");

    // the sequencer leaves idle once a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> item_stall)
        else $error("request taken without leaving idle");

    // the divider is never restarted mid-division
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // CORDIC results only arrive while the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> (state_reg == ST_COR1 || state_reg == ST_COR2))
        else $error("unexpected CORDIC completion");

endmodule

@@ test/three_wheel_odometry_update_test.sv @@
// Self-checking testbench for three_wheel_odometry_update: directed table, then random phases.
// Depends on twodom_pkg and the RTL top level; the pose predictor is local to this file.
module three_wheel_odometry_update_test;
    import twodom_pkg::*;

    localparam int     TRIG_STEPS = TRIG_ITERATIONS_DEF;
    localparam longint PI_L       = 843314857;
    localparam longint HALF_PI_L  = 421657428;
    localparam longint TWO_PI_L   = 1686629713;
    localparam longint K_L        = 652032874;
    localparam longint ONE_L      = 64'sd1073741824;
    localparam longint SMALL_L    = 4194304;

    // register indexes, byte address is 4*index
    localparam logic [1:0] REG_INCH_PER_TICK = 2'd0;
    localparam logic [1:0] REG_LEFT_OFFSET   = 2'd1;
    localparam logic [1:0] REG_RIGHT_OFFSET  = 2'd2;
    localparam logic [1:0] REG_SIDE_OFFSET   = 2'd3;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [30:0] h;
    } pose_t;

    typedef struct {
        req_t        rq;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] s;
        bit          typed;   // expected pose typed in below
        pose_t       want;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               item_valid;
    logic               item_stall;
    logic [1:0]         req_type;
    logic signed [31:0] left_ticks;
    logic signed [31:0] right_ticks;
    logic signed [31:0] side_ticks;
    logic               result_valid;
    logic               result_stall;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [30:0] heading;

    three_wheel_odometry_update u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .req_type     (req_type),
        .left_ticks   (left_ticks),
        .right_ticks  (right_ticks),
        .side_ticks   (side_ticks),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .heading      (heading)
    );

    // ---------------------------------------------------------------
    // Predictor state: its own copy of registers, baselines and pose
    // ---------------------------------------------------------------
    logic [31:0] m_ipt, m_loff, m_roff, m_soff;
    logic [31:0] m_base_l, m_base_r, m_base_s;
    logic [31:0] m_px, m_py, m_ph;

    longint atan_tbl [32] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
        'h00000001, 'h00000000
    };

    pose_t pose_q [$];       // poses still owed by the block
    int    errors;
    int    n_requests;
    int    n_results;
    bit    no_idle;          // stretches with no gaps on either side
    bit    hold_request;     // ask the receiver for one long hold-off

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint wrap_pi(longint a);
        longint z;
        z = a % TWO_PI_L;
        if (z < 0) z += TWO_PI_L;
        if (z > PI_L) z -= TWO_PI_L;
        return z;
    endfunction

    task automatic sin_cos(input longint a, output longint sn, output longint cs);
        longint z, x, y, dx, dy;
        bit flip;
        z = wrap_pi(a);
        x = K_L;
        y = 0;
        flip = 0;
        if (z > HALF_PI_L) begin
            z -= PI_L;
            flip = 1;
        end else if (z < -HALF_PI_L) begin
            z += PI_L;
            flip = 1;
        end
        z *= 4;  // Q4.28 -> Q2.30
        for (int i = 0; i < TRIG_STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_tbl[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_tbl[i];
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    function automatic longint wheel_travel(logic [31:0] now, logic [31:0] base);
        longint d;
        d = $signed(now - base);
        return clamp32((d * longint'({32'd0, m_ipt})) >>> 16);
    endfunction

    task automatic advance_pose(input logic [31:0] l, r, m);
        longint dl, dr, dm, width, theta, hx, f, g, sn, cs, h, h2, e;
        dl = wheel_travel(l, m_base_l);
        dr = wheel_travel(r, m_base_r);
        dm = wheel_travel(m, m_base_s);
        m_base_l = l;
        m_base_r = r;
        m_base_s = m;
        width = longint'({32'd0, m_loff}) + longint'({32'd0, m_roff});
        theta = 0;
        f = ONE_L;
        g = 0;
        // zero track width: no heading change
        if (width != 0) theta = clamp32(((dl - dr) * 64'sd268435456) / width);
        hx = theta >>> 1;
        if (theta != 0) begin
            sin_cos(hx, sn, cs);
            g = 2 * sn;
            // small angle: series form of 2 sin(x)/theta
            if (theta < SMALL_L && theta > -SMALL_L) f = ONE_L - ((hx * hx) >> 26) / 6;
            else f = (g * 64'sd268435456) / theta;
        end
        h  = clamp32(((dr * f) >>> 30) + ((longint'({32'd0, m_roff}) * g) >>> 30));
        h2 = clamp32(((dm * f) >>> 30) + ((longint'($signed(m_soff)) * g) >>> 30));
        e = longint'($signed(m_ph)) + hx;
        sin_cos(e, sn, cs);
        m_px += 32'((h * sn + h2 * cs) >>> 30);
        m_py += 32'((h * cs - h2 * sn) >>> 30);
        m_ph = 32'(wrap_pi(longint'($signed(m_ph)) + theta));
    endtask

    task automatic predict_pose(input req_t rq, input logic [31:0] l, r, m, output pose_t p);
        if (rq == REQ_UPDATE) begin
            advance_pose(l, r, m);
        end else begin
            if (rq == REQ_FULL_RESET || rq == REQ_CLEAR_POSE) begin
                m_px = 0;
                m_py = 0;
                m_ph = 0;
            end
            if (rq == REQ_FULL_RESET || rq == REQ_CLEAR_BASE) begin
                m_base_l = 0;
                m_base_r = 0;
                m_base_s = 0;
            end
        end
        p.x = m_px;
        p.y = m_py;
        p.h = m_ph[30:0];
    endtask

    // ---------------------------------------------------------------
    // Clock, reset and the limit on the run
    // ---------------------------------------------------------------
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: random stall, plus one long hold-off counted here
    // ---------------------------------------------------------------
    int stall_left;
    int hold_left;

    initial
    begin
        stall_left = 0;
        hold_left  = 0;
    end

    always @(negedge clk)
    begin
        int pick;
        if (hold_request) begin
            hold_request = 0;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            result_stall <= 1'b1;
        end else if (no_idle) begin
            result_stall <= 1'b0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                result_stall <= 1'b0;
            end else begin
                // mostly short stalls, a few long ones
                stall_left = (pick < 95) ? $urandom_range(0, 3) : $urandom_range(20, 60);
                result_stall <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result checker: oldest expected pose against each accepted result
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        pose_t want;
        if (rst_n && result_valid && !result_stall) begin
            n_results++;
            if (pose_q.size() == 0) begin
                $error("result with no request pending: x=%h y=%h heading=%h",
                       pos_x, pos_y, heading);
                errors++;
            end else begin
                want = pose_q.pop_front();
                if (pos_x !== want.x) begin
                    $error("pos_x expected %h actual %h", want.x, pos_x);
                    errors++;
                end
                if (pos_y !== want.y) begin
                    $error("pos_y expected %h actual %h", want.y, pos_y);
                    errors++;
                end
                if (heading !== want.h) begin
                    $error("heading expected %h actual %h", want.h, heading);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        logic [31:0] stored;
        stored = (idx == REG_LEFT_OFFSET || idx == REG_RIGHT_OFFSET) ? (v & 32'h7FFF_FFFF) : v;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        // read it back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== stored) begin
            $error("prdata expected %h actual %h", stored, prdata);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_INCH_PER_TICK: m_ipt  = stored;
            REG_LEFT_OFFSET:   m_loff = stored;
            REG_RIGHT_OFFSET:  m_roff = stored;
            default:           m_soff = stored;
        endcase
    endtask

    task automatic set_config(input logic [31:0] ipt, loff, roff, soff);
        write_reg(REG_INCH_PER_TICK, ipt);
        write_reg(REG_LEFT_OFFSET, loff);
        write_reg(REG_RIGHT_OFFSET, roff);
        write_reg(REG_SIDE_OFFSET, soff);
    endtask

    // ---------------------------------------------------------------
    // Request sender
    // ---------------------------------------------------------------
    task automatic send_request(input req_t rq, input logic [31:0] l, r, m,
                                input bit typed, input pose_t want);
        int gap, pick;
        pose_t p;
        gap = 0;
        if (!no_idle) begin
            pick = $urandom_range(0, 99);
            if (pick >= 60) gap = (pick < 93) ? $urandom_range(1, 3) : $urandom_range(15, 60);
        end
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid  <= 1'b1;
        req_type    <= rq;
        left_ticks  <= l;
        right_ticks <= r;
        side_ticks  <= m;
        do @(posedge clk); while (item_stall);
        n_requests++;
        predict_pose(rq, l, r, m, p);
        pose_q.push_back(typed ? want : p);
    endtask

    task automatic drain;
        @(negedge clk);
        item_valid <= 1'b0;
        wait (pose_q.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    // encoder counts kept by the random part so most updates are plausible motion
    logic [31:0] enc_l, enc_r, enc_s;

    task automatic random_request;
        int pick;
        req_t rq;
        logic [31:0] l, r, m;
        pick = $urandom_range(0, 99);
        l = $urandom;
        r = $urandom;
        m = $urandom;
        if (pick < 80) begin
            rq = REQ_UPDATE;
            if (pick < 8) begin
                // big jumps, wide turns
                enc_l += $urandom_range(0, 2_000_000) - 1_000_000;
                enc_r += $urandom_range(0, 2_000_000) - 1_000_000;
                enc_s += $urandom_range(0, 2_000_000) - 1_000_000;
            end else begin
                enc_l += $urandom_range(0, 4000) - 2000;
                enc_r += (pick < 20) ? enc_l - enc_r : $urandom_range(0, 4000) - 2000;
                enc_s += $urandom_range(0, 400) - 200;
            end
            l = enc_l;
            r = enc_r;
            m = enc_s;
        end else if (pick < 92) begin
            // raw noise on the counts
            rq = REQ_UPDATE;
            enc_l = l;
            enc_r = r;
            enc_s = m;
        end else begin
            rq = req_t'($urandom_range(1, 3));
            if (rq != REQ_CLEAR_POSE) begin
                enc_l = 0;
                enc_r = 0;
                enc_s = 0;
            end
        end
        send_request(rq, l, r, m, 1'b0, '0);
    endtask

    // ---------------------------------------------------------------
    // Directed table: expected pose typed in only where it is obvious
    // ---------------------------------------------------------------
    row_t dir_rows [] = '{
        '{REQ_CLEAR_POSE,  32'h0,        32'h0,        32'h0,        1, '0},
        '{REQ_UPDATE,      32'h0,        32'h0,        32'h0,        1, '0},
        '{REQ_UPDATE,      32'd1000,     32'd1000,     32'd0,        0, '0},
        '{REQ_UPDATE,      32'd2000,     32'd1000,     32'd50,       0, '0},
        '{REQ_UPDATE,      32'd2100,     32'd1900,     32'd40,       0, '0},
        '{REQ_UPDATE,      32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, '0},
        '{REQ_UPDATE,      32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, '0},
        '{REQ_FULL_RESET,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, '0},
        '{REQ_UPDATE,      32'd100,      -32'sd100,    32'd7,        0, '0},
        '{REQ_CLEAR_BASE,  32'h55555555, 32'hAAAAAAAA, 32'h12345678, 0, '0},
        '{REQ_UPDATE,      32'd5,        32'd5,        32'd5,        0, '0},
        '{REQ_UPDATE,      -32'sd40000,  32'd40000,    32'd0,        0, '0},
        '{REQ_UPDATE,      -32'sd90000,  32'd90000,    32'd300,      0, '0},
        '{REQ_UPDATE,      -32'sd140000, 32'd140000,   -32'sd300,    0, '0},
        '{REQ_UPDATE,      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, '0},
        '{REQ_CLEAR_POSE,  32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF, 1, '0},
        '{REQ_UPDATE,      32'h0,        32'h0,        32'h0,        0, '0},
        '{REQ_FULL_RESET,  32'h0,        32'h0,        32'h0,        1, '0}
    };

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic [31:0] ph_ipt [6];
        logic [31:0] ph_loff [6];
        logic [31:0] ph_roff [6];
        logic [31:0] ph_soff [6];
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        item_valid = 0;
        req_type = 0;
        left_ticks = 0;
        right_ticks = 0;
        side_ticks = 0;
        result_stall = 0;
        hold_request = 0;
        no_idle = 0;
        errors = 0;
        n_requests = 0;
        n_results = 0;
        enc_l = 0;
        enc_r = 0;
        enc_s = 0;
        m_ipt = INCH_PER_TICK_RST;
        m_loff = {1'b0, LEFT_OFFSET_RST};
        m_roff = {1'b0, RIGHT_OFFSET_RST};
        m_soff = SIDE_OFFSET_RST;
        m_base_l = 0;
        m_base_r = 0;
        m_base_s = 0;
        m_px = 0;
        m_py = 0;
        m_ph = 0;
        rst_n = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed part runs on the reset register values
        foreach (dir_rows[i])
            send_request(dir_rows[i].rq, dir_rows[i].l, dir_rows[i].r, dir_rows[i].s,
                         dir_rows[i].typed, dir_rows[i].want);
        drain();

        // settings per phase: defaults, maxima, minima with zero track width, random twice, and a track width of one
        ph_ipt  = '{INCH_PER_TICK_RST, 32'hFFFFFFFF, 32'd1, $urandom, $urandom, 32'd65536};
        ph_loff = '{32'(LEFT_OFFSET_RST), 32'hFFFFFFFF, 32'd0, $urandom, $urandom, 32'd1};
        ph_roff = '{32'(RIGHT_OFFSET_RST), 32'h7FFFFFFF, 32'd0, $urandom, $urandom, 32'd0};
        ph_soff = '{SIDE_OFFSET_RST, 32'h7FFFFFFF, 32'h80000000, $urandom, $urandom,
                    32'hFFFF0000};
        for (int ph = 0; ph < 6; ph++) begin
            set_config(ph_ipt[ph], ph_loff[ph], ph_roff[ph], ph_soff[ph]);
            for (int k = 0; k < 180; k++) begin
                // phase 0: sender keeps offering during a long receiver hold-off
                if (ph == 0 && k == 40) begin
                    no_idle = 1;
                    hold_request = 1;
                end
                if (ph == 0 && k == 60) no_idle = 0;
                // a stretch with no gaps on either side
                if (ph == 3) no_idle = (k >= 50 && k < 90);
                random_request();
            end
            no_idle = 0;
            drain();  // sender pauses until every pose has come
        end

        $display("Covered %0d requests, %0d results checked, over 6 register settings",
                 n_requests, n_results);
        $display("including zero track width, saturating travel and a long result hold-off");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/twodom_pkg.sv
rtl/twodom_mul.sv
rtl/twodom_div.sv
rtl/twodom_cordic.sv
rtl/three_wheel_odometry_update.sv
test/three_wheel_odometry_update_test.sv
